// ===== design/ps2_scancode_to_ascii_core_assert.svh =====
// Assertion macros for the PS/2 scan code decoder.
// Used by ps2_scancode_to_ascii_core; expects clk_i and rst_ni in scope.
`ifndef PS2_SCANCODE_TO_ASCII_CORE_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PS2SC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PS2SC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ps2sc_pkg.sv =====
// Types and constants for the PS/2 scan code set 2 decoder.
// No dependencies; used by the decode slice and the top level.
`timescale 1ns / 1ps

package ps2sc_pkg;

  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_SKIP = 2'd1,
    PFX_EXT  = 2'd2
  } prefix_e;

  // prefix and special make codes
  localparam logic [7:0] SC_RELEASE = 8'hF0;
  localparam logic [7:0] SC_EXTEND  = 8'hE0;
  localparam logic [7:0] SC_CAPS    = 8'h58;
  localparam logic [7:0] SC_SPACE   = 8'h29;
  localparam logic [7:0] SC_BKSP    = 8'h66;
  localparam logic [7:0] SC_TAB     = 8'h0D;
  localparam logic [7:0] SC_ENTER   = 8'h5A;
  localparam logic [7:0] SC_ESCAPE  = 8'h76;

  localparam logic [6:0] ASCII_SPACE = 7'h20;
  localparam logic [6:0] ASCII_BS    = 7'h08;
  localparam logic [6:0] ASCII_TAB   = 7'h09;
  localparam logic [6:0] ASCII_LF    = 7'h0A;
  localparam logic [6:0] ASCII_UC_A  = 7'h41;
  localparam logic [6:0] ASCII_LC_A  = 7'h61;
  localparam logic [6:0] ASCII_ZERO  = 7'h30;

  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned NUM_DIGITS  = 10;
  localparam int unsigned NUM_FKEYS   = 12;

  // make codes for a..z
  localparam logic [7:0] LETTER_CODES [NUM_LETTERS] = '{
    8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B, 8'h42, 8'h4B,
    8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C, 8'h3C, 8'h2A, 8'h1D, 8'h22,
    8'h35, 8'h1A
  };

  // make codes for 0..9
  localparam logic [7:0] DIGIT_CODES [NUM_DIGITS] = '{
    8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46
  };

  // F1..F12 and the text attribute each requests
  localparam logic [7:0] FKEY_CODES [NUM_FKEYS] = '{
    8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01, 8'h09, 8'h78, 8'h07
  };
  localparam logic [7:0] FKEY_COLORS [NUM_FKEYS] = '{
    8'h0F, 8'h02, 8'h1E, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02
  };

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       color_valid;
    logic [7:0] color_value;
    logic       clear_request;
    logic       caps_state;
  } result_t;

  // decode outcome: result beat plus next decoder state
  typedef struct packed {
    result_t res;
    prefix_e prefix;
    logic    caps;
  } dec_t;

endpackage

// ===== design/ps2sc_if.sv =====
// Valid/ready channel interfaces for scan bytes and decoded results.
// No dependencies.
`timescale 1ns / 1ps

interface ps2sc_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2sc_result_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [6:0] char_code;
  logic       color_valid;
  logic [7:0] color_value;
  logic       clear_request;
  logic       caps_state;

  modport source (
    output valid, output char_valid, output char_code, output color_valid,
    output color_value, output clear_request, output caps_state, input ready
  );
  modport sink (
    input valid, input char_valid, input char_code, input color_valid,
    input color_value, input clear_request, input caps_state, output ready
  );
endinterface

// ===== design/ps2sc_decode.sv =====
// Combinational decode of one scan code set 2 byte against the prefix state.
// Depends on ps2sc_pkg.
`timescale 1ns / 1ps

module ps2sc_decode (
  input  logic [7:0]         scan_byte_i,
  input  ps2sc_pkg::prefix_e prefix_i,
  input  logic               caps_i,
  output ps2sc_pkg::dec_t    dec_o
);
  import ps2sc_pkg::*;

  logic       letter_hit;
  logic [4:0] letter_idx;
  logic       digit_hit;
  logic [3:0] digit_idx;
  logic       fkey_hit;
  logic [3:0] fkey_idx;
  dec_t       dec;

  // table matches; codes are unique so OR-ing the indices is safe
  always_comb begin
    letter_hit = 1'b0;
    letter_idx = '0;
    digit_hit  = 1'b0;
    digit_idx  = '0;
    fkey_hit   = 1'b0;
    fkey_idx   = '0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (LETTER_CODES[i] == scan_byte_i) begin
        letter_hit = 1'b1;
        letter_idx = letter_idx | 5'(i);
      end
    end
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (DIGIT_CODES[i] == scan_byte_i) begin
        digit_hit = 1'b1;
        digit_idx = digit_idx | 4'(i);
      end
    end
    for (int i = 0; i < NUM_FKEYS; i++) begin
      if (FKEY_CODES[i] == scan_byte_i) begin
        fkey_hit = 1'b1;
        fkey_idx = fkey_idx | 4'(i);
      end
    end
  end

  always_comb begin
    dec        = '0;
    dec.prefix = PFX_NONE;
    dec.caps   = caps_i;
    case (prefix_i)
      PFX_SKIP: dec.prefix = PFX_NONE;
      PFX_EXT:  dec.prefix = (scan_byte_i == SC_RELEASE) ? PFX_SKIP : PFX_NONE;
      default: begin
        if (scan_byte_i == SC_RELEASE) begin
          dec.prefix = PFX_SKIP;
        end else if (scan_byte_i == SC_EXTEND) begin
          dec.prefix = PFX_EXT;
        end else if (letter_hit) begin
          dec.res.char_valid = 1'b1;
          dec.res.char_code  = (caps_i ? ASCII_UC_A : ASCII_LC_A) + {2'b00, letter_idx};
        end else if (digit_hit) begin
          dec.res.char_valid = 1'b1;
          dec.res.char_code  = ASCII_ZERO + {3'b000, digit_idx};
        end else begin
          case (scan_byte_i)
            SC_SPACE: begin
              dec.res.char_valid = 1'b1;
              dec.res.char_code  = ASCII_SPACE;
            end
            SC_BKSP: begin
              dec.res.char_valid = 1'b1;
              dec.res.char_code  = ASCII_BS;
            end
            SC_TAB: begin
              dec.res.char_valid = 1'b1;
              dec.res.char_code  = ASCII_TAB;
            end
            SC_ENTER: begin
              dec.res.char_valid = 1'b1;
              dec.res.char_code  = ASCII_LF;
            end
            SC_CAPS:   dec.caps = ~caps_i;
            SC_ESCAPE: dec.res.clear_request = 1'b1;
            default: begin
              if (fkey_hit) begin
                dec.res.color_valid = 1'b1;
                dec.res.color_value = FKEY_COLORS[fkey_idx];
              end
            end
          endcase
        end
      end
    endcase
    dec.res.caps_state = dec.caps;
  end

  assign dec_o = dec;

endmodule

// ===== design/ps2_scancode_to_ascii_core.sv =====
// Top level of the PS/2 scan code set 2 decoder: byte register, decode, result register.
// Depends on ps2sc_pkg, ps2sc_if, ps2sc_decode and the assertion macro header.
`timescale 1ns / 1ps
//
//  channel   | dir | payload                                           | beats
//  ----------+-----+---------------------------------------------------+---------------
//  scan_i    | in  | scan_byte[7:0]                                    | 1 per byte
//  result_o  | out | char_valid, char_code, color_valid, color_value,  | 1 per byte
//            |     | clear_request, caps_state                         |
//
//  One beat in and one beat out per cycle while result_o is not stalled; a byte passes
//  the byte register, then the result register after the decode compares.
//  Prefix and caps lock state move on as a byte enters the result register.
//  Asynchronous active-low reset clears both valid flags, the prefix and caps lock.
//  A stall on result_o holds the result; scan_i takes a beat while the byte register
//  is empty or drains in the same cycle.

module ps2_scancode_to_ascii_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  ps2sc_scan_if.sink              scan_i,
  ps2sc_result_if.source          result_o
);
  import ps2sc_pkg::*;

`include "ps2_scancode_to_ascii_core_assert.svh"

  // byte register stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // result register stage
  logic       out_valid_q;
  result_t    out_res_q;

  // decoder state
  prefix_e    prefix_q;
  logic       caps_q;

  logic       out_free;
  logic       s1_move;
  logic       s1_load;
  dec_t       dec;

  // result slot frees when empty or taken this cycle
  assign out_free = !out_valid_q || result_o.ready;
  assign s1_move  = s1_valid_q && out_free;
  assign scan_i.ready = !s1_valid_q || s1_move;
  assign s1_load  = scan_i.valid && scan_i.ready;

  ps2sc_decode u_decode (
    .scan_byte_i (s1_byte_q),
    .prefix_i    (prefix_q),
    .caps_i      (caps_q),
    .dec_o       (dec)
  );

  // control: valid flags and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prefix_q    <= PFX_NONE;
      caps_q      <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
        prefix_q    <= dec.prefix;
        caps_q      <= dec.caps;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_byte_q <= scan_i.scan_byte;
    end
    if (s1_move) begin
      out_res_q <= dec.res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.char_valid    = out_res_q.char_valid;
  assign result_o.char_code     = out_res_q.char_code;
  assign result_o.color_valid   = out_res_q.color_valid;
  assign result_o.color_value   = out_res_q.color_value;
  assign result_o.clear_request = out_res_q.clear_request;
  assign result_o.caps_state    = out_res_q.caps_state;

  // at most one kind of event per result
  `PS2SC_ASSERT_IMP(a_one_event, out_valid_q, $onehot0({out_res_q.char_valid, out_res_q.color_valid, out_res_q.clear_request}), "more than one event in a result")
  // fields carry zero when their flag is low
  `PS2SC_ASSERT_IMP(a_char_zero, out_valid_q && !out_res_q.char_valid, out_res_q.char_code == 7'd0, "char_code set without char_valid")
  `PS2SC_ASSERT_IMP(a_color_zero, out_valid_q && !out_res_q.color_valid, out_res_q.color_value == 8'd0, "color_value set without color_valid")
  // decoder state changes only when a byte is decoded
  `PS2SC_ASSERT_NXT(a_state_hold, !s1_move, $stable(caps_q) && $stable(prefix_q), "decoder state moved without a byte")
  // release byte with no prefix pending arms a skip
  `PS2SC_ASSERT_NXT(a_release_skip, s1_move && prefix_q == PFX_NONE && s1_byte_q == SC_RELEASE, prefix_q == PFX_SKIP, "release prefix not latched")

endmodule
